>>> rtl/hbs_pkg.sv
// Shared types, constants and register codes of the heightfield bilinear sampler.
package hbs_pkg;

   localparam int DEF_GRID_CELLS     = 128;
   localparam int DEF_TILES_PER_SIDE = 64;

   // Tile size of 1600/3 world units, expressed in units of 1/768.
   localparam int TILE_Q8X3      = 409600;
   localparam int HALF_TILE_Q8X3 = 204800;

   localparam int ADDR_W_MAX   = 17;
   localparam int WGT_W        = 17;
   localparam int QUEUE_DEPTH  = 8;
   localparam int FRONT_STAGES = 5;

   localparam int DEN_CODE16 = 65535;
   localparam int DEN_CODE8  = 255;

   localparam logic [1:0] MODE_DIRECT = 2'd0;
   localparam logic [1:0] MODE_CODE16 = 2'd1;
   localparam logic [1:0] MODE_CODE8  = 2'd2;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [31:0] NO_GROUND = 32'h8000_0000;

   typedef enum logic [2:0] {
      CSR_MIN_HEIGHT      = 3'd0,
      CSR_MAX_HEIGHT      = 3'd1,
      CSR_FLAT_TILE       = 3'd2,
      CSR_SAMPLE_MODE     = 3'd3,
      CSR_LOADED_TILE_COL = 3'd4,
      CSR_LOADED_TILE_ROW = 3'd5,
      CSR_LOADED_MAP      = 3'd6,
      CSR_TILE_PRESENT    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] min_height;
      logic signed [31:0] max_height;
      logic               flat_tile;
      logic [1:0]         sample_mode;
      logic [5:0]         loaded_tile_col;
      logic [5:0]         loaded_tile_row;
      logic [9:0]         loaded_map;
      logic               tile_present;
   } csr_type;

   typedef enum logic [1:0] {
      OP_WRITE   = 2'd0,
      OP_DEQUANT = 2'd1,
      OP_REPLY   = 2'd2,
      OP_SAMPLE  = 2'd3
   } op_type;

   typedef struct packed {
      op_type                          op;
      logic                            wide_code;
      logic                            res_valid;
      logic [31:0]                     data;
      logic [3:0][ADDR_W_MAX-1:0]      addr;
      logic [3:0][WGT_W-1:0]           wgt;
   } item_type;

endpackage

>>> rtl/hbs_front.sv
// Front pipeline: locates the tile and cell of a query and classifies every command.
module hbs_front #(
   parameter int GRID_CELLS     = hbs_pkg::DEF_GRID_CELLS,
   parameter int TILES_PER_SIDE = hbs_pkg::DEF_TILES_PER_SIDE
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                req_cmd,
   input  logic [14:0]         req_sample_index,
   input  logic signed [31:0]  req_sample_value,
   input  logic [9:0]          req_map_number,
   input  logic signed [23:0]  req_pos_x,
   input  logic signed [23:0]  req_pos_y,
   input  hbs_pkg::csr_type    csr,
   output logic                push,
   output hbs_pkg::item_type   push_item,
   output logic [$clog2(hbs_pkg::FRONT_STAGES+1)-1:0] inflight
);
   import hbs_pkg::*;

   localparam int GS     = GRID_CELLS + 1;
   localparam int DEPTH  = GS * GS;
   localparam int ZERO_Q = TILES_PER_SIDE * HALF_TILE_Q8X3;
   localparam int NUM_W  = 28;
   localparam int U_W    = 13;
   localparam int Q_W    = 26;
   localparam int R_W    = 19;
   localparam int RG_W   = R_W + 9;
   localparam int U2_W   = RG_W - 6;
   localparam int VM_W   = U2_W + 22;
   localparam int V_W    = 17;
   localparam int C_W    = 9;
   localparam int RECIP1 = 5243;     // 2^17/25, rounded up
   localparam int RECIP2 = 2684355;  // 2^26/25, rounded up
   localparam int LAST   = FRONT_STAGES - 1;

   logic [FRONT_STAGES-1:0] vld_ff;
   logic                    cmd_ff [FRONT_STAGES];
   logic [14:0]             idx_ff [FRONT_STAGES];
   logic signed [31:0]      val_ff [FRONT_STAGES];
   logic [9:0]              map_ff [FRONT_STAGES];

   logic signed [NUM_W-1:0] num1_ff [2];
   logic signed [NUM_W-1:0] num2_ff [2];
   logic signed [7:0]       t2_ff [2];
   logic signed [7:0]       t3_ff [2];
   logic signed [7:0]       t4_ff [2];
   logic signed [7:0]       t5_ff [2];
   logic [R_W-1:0]          r3_ff [2];
   logic [U2_W-1:0]         u4_ff [2];
   logic [V_W-1:0]          v5_ff [2];

   logic signed [23:0]      pos [2];
   logic signed [NUM_W-1:0] pe [2];
   logic signed [NUM_W-1:0] num_in [2];
   logic signed [NUM_W-1:0] sh [2];
   logic signed [NUM_W-1:0] u1 [2];
   logic [Q_W-1:0]          q1 [2];
   logic signed [9:0]       tw [2];
   logic signed [7:0]       t_in [2];
   logic signed [NUM_W-1:0] tq [2];
   logic signed [NUM_W-1:0] rr [2];
   logic [R_W-1:0]          r_in [2];
   logic [RG_W-1:0]         rg [2];
   logic [U2_W-1:0]         u2_in [2];
   logic [VM_W-1:0]         vm [2];
   logic [V_W-1:0]          v_in [2];

   logic [C_W-1:0]          cell_idx [2];
   logic [C_W-1:0]          frac [2];
   logic [C_W-1:0]          gfrac [2];
   logic                    tile_in_range [2];
   logic                    tile_match;
   logic [ADDR_W_MAX-1:0]   base;

   assign pos[0] = req_pos_x;
   assign pos[1] = req_pos_y;

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         pe[a]     = NUM_W'(pos[a]);
         num_in[a] = $signed(NUM_W'(ZERO_Q)) - (pe[a] + (pe[a] <<< 1));
         // Floor division by the tile size: first by 2^14, then by 25.
         sh[a]     = num1_ff[a] >>> 14;
         u1[a]     = sh[a] + $signed(NUM_W'(2500));
         q1[a]     = Q_W'(u1[a][U_W-1:0]) * Q_W'(RECIP1);
         tw[a]     = $signed({1'b0, q1[a][Q_W-1:17]}) - 10'sd100;
         t_in[a]   = tw[a][7:0];
         tq[a]     = $signed(NUM_W'(t2_ff[a])) * $signed(NUM_W'(TILE_Q8X3));
         rr[a]     = num2_ff[a] - tq[a];
         r_in[a]   = rr[a][R_W-1:0];
         rg[a]     = RG_W'(r3_ff[a]) * RG_W'(GRID_CELLS);
         u2_in[a]  = rg[a][RG_W-1:6];
         vm[a]     = VM_W'(u4_ff[a]) * VM_W'(RECIP2);
         v_in[a]   = vm[a][26 +: V_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[FRONT_STAGES-2:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff[0] <= req_cmd;
      idx_ff[0] <= req_sample_index;
      val_ff[0] <= req_sample_value;
      map_ff[0] <= req_map_number;
      for (int s = 1; s < FRONT_STAGES; s++) begin
         cmd_ff[s] <= cmd_ff[s-1];
         idx_ff[s] <= idx_ff[s-1];
         val_ff[s] <= val_ff[s-1];
         map_ff[s] <= map_ff[s-1];
      end
      for (int a = 0; a < 2; a++) begin
         num1_ff[a] <= num_in[a];
         num2_ff[a] <= num1_ff[a];
         t2_ff[a]   <= t_in[a];
         r3_ff[a]   <= r_in[a];
         t3_ff[a]   <= t2_ff[a];
         u4_ff[a]   <= u2_in[a];
         t4_ff[a]   <= t3_ff[a];
         v5_ff[a]   <= v_in[a];
         t5_ff[a]   <= t4_ff[a];
      end
   end

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         cell_idx[a] = v5_ff[a][V_W-1:8];
         frac[a] = {1'b0, v5_ff[a][7:0]};
         if (cell_idx[a] >= C_W'(GRID_CELLS)) begin
            cell_idx[a] = C_W'(GRID_CELLS - 1);
            frac[a] = C_W'(256);
         end
         gfrac[a] = C_W'(256) - frac[a];
         tile_in_range[a] = !t5_ff[a][7] && (t5_ff[a] < 8'(TILES_PER_SIDE));
      end
      // The tile from the Y position selects the column, the one from X the row.
      tile_match = tile_in_range[0] && tile_in_range[1]
                   && (map_ff[LAST] == csr.loaded_map)
                   && (t5_ff[1] == {2'b00, csr.loaded_tile_col})
                   && (t5_ff[0] == {2'b00, csr.loaded_tile_row})
                   && csr.tile_present;
      base = ADDR_W_MAX'(cell_idx[1]) * ADDR_W_MAX'(GS) + ADDR_W_MAX'(cell_idx[0]);

      push_item = '0;
      push      = 1'b0;
      if (cmd_ff[LAST] == CMD_LOAD) begin
         push              = vld_ff[LAST]
                             && (ADDR_W_MAX'(idx_ff[LAST]) < ADDR_W_MAX'(DEPTH));
         push_item.addr[0] = ADDR_W_MAX'(idx_ff[LAST]);
         if (csr.sample_mode == MODE_CODE16) begin
            push_item.op        = OP_DEQUANT;
            push_item.wide_code = 1'b1;
            push_item.data      = {16'd0, val_ff[LAST][15:0]};
         end else if (csr.sample_mode == MODE_CODE8) begin
            push_item.op   = OP_DEQUANT;
            push_item.data = {24'd0, val_ff[LAST][7:0]};
         end else begin
            push_item.op   = OP_WRITE;
            push_item.data = val_ff[LAST];
         end
      end else begin
         push = vld_ff[LAST];
         if (!tile_match) begin
            push_item.op   = OP_REPLY;
            push_item.data = NO_GROUND;
         end else if (csr.flat_tile) begin
            push_item.op        = OP_REPLY;
            push_item.data      = csr.min_height;
            push_item.res_valid = 1'b1;
         end else begin
            push_item.op      = OP_SAMPLE;
            push_item.addr[0] = base;
            push_item.addr[1] = base + ADDR_W_MAX'(1);
            push_item.addr[2] = base + ADDR_W_MAX'(GS);
            push_item.addr[3] = base + ADDR_W_MAX'(GS + 1);
            push_item.wgt[0]  = WGT_W'(gfrac[0]) * WGT_W'(gfrac[1]);
            push_item.wgt[1]  = WGT_W'(frac[0]) * WGT_W'(gfrac[1]);
            push_item.wgt[2]  = WGT_W'(gfrac[0]) * WGT_W'(frac[1]);
            push_item.wgt[3]  = WGT_W'(frac[0]) * WGT_W'(frac[1]);
         end
      end
   end

   assign inflight = $bits(inflight)'($countones(vld_ff));

endmodule

>>> rtl/hbs_queue.sv
// Short command queue between the front pipeline and the execution unit.
module hbs_queue #(
   parameter int DEPTH = hbs_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  hbs_pkg::item_type         push_item,
   input  logic                      pop,
   output hbs_pkg::item_type         head,
   output logic                      not_empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   import hbs_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   item_type       slot_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      count_in = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head      = slot_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < CW'(DEPTH)))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("queue read while empty");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (count_ff == $past(count_ff) + CW'($past(push)) - CW'($past(pop))))
      else $error("queue fill count lost track of transfers");

endmodule

>>> rtl/hbs_back.sv
// Execution unit: grid memory, sample dequantization and bilinear accumulation.
module hbs_back #(
   parameter int GRID_CELLS = hbs_pkg::DEF_GRID_CELLS
) (
   input  logic                clock,
   input  logic                reset,
   input  hbs_pkg::csr_type    csr,
   input  hbs_pkg::item_type   head,
   input  logic                not_empty,
   output logic                pop,
   output logic                rsp_strobe,
   output logic signed [31:0]  rsp_height,
   output logic                rsp_valid_res
);
   import hbs_pkg::*;

   localparam int GS    = GRID_CELLS + 1;
   localparam int DEPTH = GS * GS;
   localparam int AW    = $clog2(DEPTH);
   localparam int NW    = 52;
   localparam int DW    = 17;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_MUL_LO = 8'b0000_0010,
      S_MUL_HI = 8'b0000_0100,
      S_PREP   = 8'b0000_1000,
      S_DIV    = 8'b0001_0000,
      S_WRITE  = 8'b0010_0000,
      S_QRD    = 8'b0100_0000,
      S_QWAIT  = 8'b1000_0000
   } state_type;

   state_type          state_ff, state_in;
   item_type           item_ff, item_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [15:0]        code_ff, code_in;
   logic [31:0]        plo_ff, plo_in;
   logic signed [33:0] phi_ff, phi_in;
   logic [NW-1:0]      num_ff, num_in;
   logic               neg_ff, neg_in;
   logic [31:0]        quo_ff, quo_in;

   logic [31:0]        grid_ff [DEPTH];
   logic [31:0]        rd_data_ff;
   logic               rdv_ff, rdv_in;
   logic [WGT_W-1:0]   w1_ff, w1_in;
   logic signed [48:0] prod_ff, prod_in;
   logic               pv_ff, pv_in;
   logic signed [49:0] acc_ff, acc_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [31:0]        rsp_height_ff, rsp_height_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               mem_we;
   logic [AW-1:0]      mem_addr;
   logic [31:0]        mem_wdata;

   logic signed [32:0] diff;
   logic [DW-1:0]      den;
   logic [DW-1:0]      den2;
   logic signed [NW-1:0] p52;
   logic signed [NW-1:0] n52;
   logic [NW-1:0]      dq_hi;
   logic [NW-1:0]      dq_lo;
   logic signed [49:0] rounded;

   always_comb begin
      diff     = 33'(csr.max_height) - 33'(csr.min_height);
      den      = item_ff.wide_code ? DW'(DEN_CODE16) : DW'(DEN_CODE8);
      den2     = den << 1;
      p52      = {{2{phi_ff[33]}}, phi_ff, 16'd0} + {20'd0, plo_ff};
      n52      = (p52 <<< 1) + $signed(NW'(den));
      dq_hi    = item_ff.wide_code ? (num_ff >> 16) : (num_ff >> 8);
      dq_lo    = num_ff & NW'(den);
      rounded  = acc_ff + 50'sd32768;

      state_in      = state_ff;
      item_in       = item_ff;
      cnt_in        = cnt_ff;
      code_in       = code_ff;
      plo_in        = plo_ff;
      phi_in        = phi_ff;
      num_in        = num_ff;
      neg_in        = neg_ff;
      quo_in        = quo_ff;
      rdv_in        = 1'b0;
      w1_in         = w1_ff;
      prod_in       = $signed(rd_data_ff) * $signed({1'b0, w1_ff});
      pv_in         = rdv_ff;
      acc_in        = pv_ff ? acc_ff + 50'(prod_ff) : acc_ff;
      rsp_strobe_in = 1'b0;
      rsp_height_in = rsp_height_ff;
      rsp_valid_in  = rsp_valid_ff;
      pop           = 1'b0;
      mem_we        = 1'b0;
      mem_addr      = item_ff.addr[cnt_ff[1:0]][AW-1:0];
      mem_wdata     = head.data;

      case (state_ff)
         S_IDLE: begin
            if (not_empty) begin
               pop = 1'b1;
               case (head.op)
                  OP_WRITE: begin
                     mem_we   = 1'b1;
                     mem_addr = head.addr[0][AW-1:0];
                  end
                  OP_REPLY: begin
                     rsp_strobe_in = 1'b1;
                     rsp_height_in = head.data;
                     rsp_valid_in  = head.res_valid;
                  end
                  OP_DEQUANT: begin
                     item_in  = head;
                     code_in  = head.data[15:0];
                     state_in = S_MUL_LO;
                  end
                  OP_SAMPLE: begin
                     item_in  = head;
                     cnt_in   = '0;
                     acc_in   = '0;
                     state_in = S_QRD;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_MUL_LO: begin
            plo_in   = 32'(code_ff) * 32'(diff[15:0]);
            state_in = S_MUL_HI;
         end
         S_MUL_HI: begin
            phi_in   = $signed({2'b00, code_ff}) * $signed(diff[32:16]);
            state_in = S_PREP;
         end
         S_PREP: begin
            // A negative dividend is turned into a ceiling on its magnitude. The
            // halving leaves a division by 2^k-1 alone.
            neg_in   = n52[NW-1];
            num_in   = (n52[NW-1] ? NW'(-n52 + $signed(NW'(den2)) - NW'(1))
                                  : NW'(n52)) >> 1;
            quo_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            // With x = hi*2^k + lo, x = hi*(2^k-1) + (hi + lo): fold until hi is zero.
            if (dq_hi != '0) begin
               quo_in = quo_ff + dq_hi[31:0];
               num_in = dq_hi + dq_lo;
            end else begin
               if (dq_lo == NW'(den)) begin
                  quo_in = quo_ff + 32'd1;
               end
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            mem_we    = 1'b1;
            mem_addr  = item_ff.addr[0][AW-1:0];
            mem_wdata = neg_ff ? csr.min_height - quo_ff : csr.min_height + quo_ff;
            state_in  = S_IDLE;
         end
         S_QRD: begin
            rdv_in = 1'b1;
            w1_in  = item_ff.wgt[cnt_ff[1:0]];
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff[1:0] == 2'd3) begin
               state_in = S_QWAIT;
            end
         end
         S_QWAIT: begin
            if (!rdv_ff && !pv_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_height_in = rounded[47:16];
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         rdv_ff        <= 1'b0;
         pv_ff         <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rdv_ff        <= rdv_in;
         pv_ff         <= pv_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      code_ff       <= code_in;
      plo_ff        <= plo_in;
      phi_ff        <= phi_in;
      num_ff        <= num_in;
      neg_ff        <= neg_in;
      quo_ff        <= quo_in;
      w1_ff         <= w1_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      rsp_height_ff <= rsp_height_in;
      rsp_valid_ff  <= rsp_valid_in;
   end

   // Single-port grid memory with a registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_ff[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= grid_ff[mem_addr];
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_height    = rsp_height_ff;
   assign rsp_valid_res = rsp_valid_ff;

endmodule

>>> rtl/heightfield_bilinear_sampler.sv
// Top level of the heightfield bilinear sampler: registers, handshake and unit wiring.
//
// Commands enter through a five-stage front pipeline and a small queue, and
// busy rises once the front pipeline and queue together hold as many commands
// as the queue has slots. The execution unit, with its single-port grid
// memory, takes one command at a time from the queue and sets the rate: a
// query that interpolates is issued, makes four memory reads in turn and then
// drains the multiply-accumulate; a direct load or a query answered without
// the grid is done as it is taken from the queue; and a load in one of the
// code modes runs the folding division by 2^k-1 of the dequantization before
// it writes the grid. A query result is driven for one cycle with rsp_strobe;
// the receiver cannot hold it off.
module heightfield_bilinear_sampler #(
   parameter int GRID_CELLS     = hbs_pkg::DEF_GRID_CELLS,
   parameter int TILES_PER_SIDE = hbs_pkg::DEF_TILES_PER_SIDE
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_cmd,
   input  logic [14:0]        req_sample_index,
   input  logic signed [31:0] req_sample_value,
   input  logic [9:0]         req_map_number,
   input  logic signed [23:0] req_pos_x,
   input  logic signed [23:0] req_pos_y,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_height,
   output logic               rsp_valid_res,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import hbs_pkg::*;

   localparam int QCW = $clog2(QUEUE_DEPTH + 1) + 1;

   csr_type  csr_ff, csr_in;
   logic     accept;
   logic     push;
   item_type push_item;
   logic     pop;
   item_type head;
   logic     not_empty;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
   logic [$clog2(FRONT_STAGES+1)-1:0] inflight;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_MIN_HEIGHT:      csr_in.min_height      = csr_wdata;
            CSR_MAX_HEIGHT:      csr_in.max_height      = csr_wdata;
            CSR_FLAT_TILE:       csr_in.flat_tile       = csr_wdata[0];
            CSR_SAMPLE_MODE:     csr_in.sample_mode     = csr_wdata[1:0];
            CSR_LOADED_TILE_COL: csr_in.loaded_tile_col = csr_wdata[5:0];
            CSR_LOADED_TILE_ROW: csr_in.loaded_tile_row = csr_wdata[5:0];
            CSR_LOADED_MAP:      csr_in.loaded_map      = csr_wdata[9:0];
            CSR_TILE_PRESENT:    csr_in.tile_present    = csr_wdata[0];
            default:             csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // Every command in the front pipeline has a queue slot reserved for it.
   assign busy   = (QCW'(q_count) + QCW'(inflight)) >= QCW'(QUEUE_DEPTH);
   assign accept = start && !busy;

   hbs_front #(
      .GRID_CELLS     (GRID_CELLS),
      .TILES_PER_SIDE (TILES_PER_SIDE)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_cmd          (req_cmd),
      .req_sample_index (req_sample_index),
      .req_sample_value (req_sample_value),
      .req_map_number   (req_map_number),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .csr              (csr_ff),
      .push             (push),
      .push_item        (push_item),
      .inflight         (inflight)
   );

   hbs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .count     (q_count)
   );

   hbs_back #(
      .GRID_CELLS (GRID_CELLS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .csr           (csr_ff),
      .head          (head),
      .not_empty     (not_empty),
      .pop           (pop),
      .rsp_strobe    (rsp_strobe),
      .rsp_height    (rsp_height),
      .rsp_valid_res (rsp_valid_res)
   );

endmodule

>>> bench/tb_heightfield_bilinear_sampler.sv
// Self-checking testbench of the heightfield bilinear sampler: loads, queries and register phases.
module tb_heightfield_bilinear_sampler;
   timeunit 1ns;
   timeprecision 1ps;
   import hbs_pkg::*;

   localparam int GRID_SIDE  = DEF_GRID_CELLS + 1;
   localparam int GRID_DEPTH = GRID_SIDE * GRID_SIDE;
   localparam longint ZERO_Q8X3 = longint'(DEF_TILES_PER_SIDE) * HALF_TILE_Q8X3;
   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 600;

   typedef struct {
      logic        cmd;
      logic [14:0] idx;
      logic [31:0] val;
      logic [9:0]  map;
      logic [23:0] px;
      logic [23:0] py;
   } sampler_req_type;

   class height_scoreboard;
      logic [31:0] grid [GRID_DEPTH];
      bit          written [GRID_DEPTH];
      longint      min_h, max_h;
      bit          flat, present;
      logic [1:0]  mode;
      int          tcol, trow, map;
      logic [32:0] pending [$];
      int          errors;

      function new();
         min_h = 0; max_h = 0; flat = 0; present = 0; mode = MODE_DIRECT;
         tcol = 0; trow = 0; map = 0; errors = 0;
      endfunction

      function void set_reg(csr_index_type i, logic [31:0] d);
         case (i)
            CSR_MIN_HEIGHT: min_h = longint'($signed(d));
            CSR_MAX_HEIGHT: max_h = longint'($signed(d));
            CSR_FLAT_TILE: flat = d[0];
            CSR_SAMPLE_MODE: mode = d[1:0];
            CSR_LOADED_TILE_COL: tcol = d[5:0];
            CSR_LOADED_TILE_ROW: trow = d[5:0];
            CSR_LOADED_MAP: map = d[9:0];
            CSR_TILE_PRESENT: present = d[0];
            default: ;
         endcase
      endfunction

      static function longint floor_div(longint a, longint b);
         longint q;
         q = a / b;
         if ((a % b) != 0 && a < 0) q--;
         return q;
      endfunction

      // Tile, cell and weight in 1/256 (up to 256) along one axis, exact in units of 1/768.
      static function void locate(longint p, output longint t, output longint c,
                                  output longint f);
         longint num, r, v;
         num = ZERO_Q8X3 - 3 * p;
         t = floor_div(num, TILE_Q8X3);
         r = num - t * TILE_Q8X3;
         v = (r * DEF_GRID_CELLS * 256) / TILE_Q8X3;
         c = v >>> 8;
         f = v & 255;
         if (c >= DEF_GRID_CELLS) begin
            c = DEF_GRID_CELLS - 1;
            f = 256;
         end
      endfunction

      // True when the query interpolates and so reads the grid around (ix, iy).
      function bit reads_grid(sampler_req_type r, output longint ix, output longint iy);
         longint tc, tr, fx, fy;
         locate(longint'($signed(r.py)), tc, iy, fy);
         locate(longint'($signed(r.px)), tr, ix, fx);
         return r.cmd == CMD_QUERY && tc == tcol && tr == trow && r.map == map
            && present && !flat;
      endfunction

      function longint corner(longint x, longint y);
         return longint'($signed(grid[y * GRID_SIDE + x]));
      endfunction

      function void note_request(sampler_req_type r);
         longint tc, tr, ix, iy, fx, fy, gx, gy, s, h, den, code;
         bit ok;
         if (r.cmd == CMD_LOAD) begin
            if (r.idx >= GRID_DEPTH) return;
            if (mode == MODE_CODE16 || mode == MODE_CODE8) begin
               den = (mode == MODE_CODE16) ? DEN_CODE16 : DEN_CODE8;
               code = longint'(r.val) & den;
               h = min_h + floor_div(2 * code * (max_h - min_h) + den, 2 * den);
            end else begin
               h = longint'($signed(r.val));
            end
            grid[r.idx] = h[31:0];
            written[r.idx] = 1;
            return;
         end
         locate(longint'($signed(r.py)), tc, iy, fy);
         locate(longint'($signed(r.px)), tr, ix, fx);
         ok = tc >= 0 && tc < DEF_TILES_PER_SIDE && tr >= 0 && tr < DEF_TILES_PER_SIDE
            && r.map == map && tc == tcol && tr == trow && present;
         if (!ok) begin
            pending.push_back({1'b0, NO_GROUND});
         end else if (flat) begin
            pending.push_back({1'b1, min_h[31:0]});
         end else begin
            gx = 256 - fx;
            gy = 256 - fy;
            s = gx * gy * corner(ix, iy) + fx * gy * corner(ix + 1, iy)
              + gx * fy * corner(ix, iy + 1) + fx * fy * corner(ix + 1, iy + 1);
            h = (s + 32768) >>> 16;
            pending.push_back({1'b1, h[31:0]});
         end
      endfunction

      function void check_result(logic [31:0] height, logic valid_res);
         logic [32:0] want;
         if (pending.size() == 0) begin
            $error("unexpected result: height %0d valid_res %0b", $signed(height), valid_res);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (height !== want[31:0]) begin
            $error("height: expected %0d actual %0d", $signed(want[31:0]), $signed(height));
            errors++;
         end
         if (valid_res !== want[32]) begin
            $error("valid_res: expected %0b actual %0b", want[32], valid_res);
            errors++;
         end
      endfunction
   endclass

   logic               clock, reset, start, busy;
   logic               req_cmd;
   logic [14:0]        req_sample_index;
   logic signed [31:0] req_sample_value;
   logic [9:0]         req_map_number;
   logic signed [23:0] req_pos_x, req_pos_y;
   logic               rsp_strobe, rsp_valid_res;
   logic signed [31:0] rsp_height;
   logic               csr_write;
   logic [2:0]         csr_index;
   logic [31:0]        csr_wdata;

   height_scoreboard sb = new();
   bit gaps_on;
   int n_sent;
   int stall_count = 0;

   heightfield_bilinear_sampler u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_sample_index(req_sample_index),
      .req_sample_value(req_sample_value), .req_map_number(req_map_number),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .rsp_strobe(rsp_strobe), .rsp_height(rsp_height), .rsp_valid_res(rsp_valid_res),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_result(rsp_height, rsp_valid_res);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_count = 0;
      end else begin
         stall_count++;
         if (stall_count == STALL_LIMIT) begin
            $display("tb_heightfield_bilinear_sampler NOT OK");
            $finish;
         end
      end
   end

   // World position, Q15.8, that falls at remainder rr within the given tile.
   function automatic int pos_in(int tile, int rr);
      longint num;
      num = longint'(tile) * TILE_Q8X3 + rr;
      num -= (num + 1) % 3;
      if (num < 0) num += 3;
      return int'((ZERO_Q8X3 - num) / 3);
   endfunction

   task automatic send(sampler_req_type r);
      start <= 1;
      req_cmd <= r.cmd;
      req_sample_index <= r.idx;
      req_sample_value <= r.val;
      req_map_number <= r.map;
      req_pos_x <= r.px;
      req_pos_y <= r.py;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(r);
      n_sent++;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic load(int idx, logic [31:0] val);
      sampler_req_type r;
      r = '{cmd: CMD_LOAD, idx: idx[14:0], val: val, map: 10'($urandom),
            px: 24'($urandom), py: 24'($urandom)};
      send(r);
   endtask

   // Loads any corner the query would read that has not been written yet.
   task automatic query(int map, int px, int py);
      sampler_req_type r;
      longint ix, iy;
      int k;
      r = '{cmd: CMD_QUERY, idx: 15'($urandom), val: $urandom, map: map[9:0],
            px: px[23:0], py: py[23:0]};
      if (sb.reads_grid(r, ix, iy)) begin
         for (int d = 0; d < 4; d++) begin
            k = int'((iy + d / 2) * GRID_SIDE + ix + d % 2);
            if (!sb.written[k]) load(k, $urandom);
         end
      end
      send(r);
   endtask

   task automatic tile_query(int rx, int ry);
      query(sb.map, pos_in(sb.trow, rx), pos_in(sb.tcol, ry));
   endtask

   task automatic write_reg(csr_index_type i, logic [31:0] d);
      csr_write <= 1;
      csr_index <= i;
      csr_wdata <= d;
      @(posedge clock);
      sb.set_reg(i, d);
   endtask

   // Registers change only once the block has drained all earlier work.
   task automatic set_phase(logic [31:0] mn, logic [31:0] mx, bit flat, logic [1:0] mode,
                            int col, int row, int map, bit present);
      start <= 0;
      while (sb.pending.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      write_reg(CSR_MIN_HEIGHT, mn);
      write_reg(CSR_MAX_HEIGHT, mx);
      write_reg(CSR_FLAT_TILE, flat);
      write_reg(CSR_SAMPLE_MODE, mode);
      write_reg(CSR_LOADED_TILE_COL, col);
      write_reg(CSR_LOADED_TILE_ROW, row);
      write_reg(CSR_LOADED_MAP, map);
      write_reg(CSR_TILE_PRESENT, present);
      csr_write <= 0;
   endtask

   function automatic logic [31:0] pick_height();
      case ($urandom_range(0, 3))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_phase(int n);
      int stop, k;
      stop = n_sent + n;
      while (n_sent < stop) begin
         k = $urandom_range(0, 99);
         if (k < 40) begin
            if ($urandom_range(0, 19) == 0) load($urandom_range(GRID_DEPTH, 32767), $urandom);
            else load($urandom_range(0, GRID_DEPTH - 1), $urandom);
         end else if (k < 85) begin
            tile_query($urandom_range(0, TILE_Q8X3 - 1), $urandom_range(0, TILE_Q8X3 - 1));
         end else begin
            query(($urandom_range(0, 1) == 0) ? sb.map : $urandom, $urandom, $urandom);
         end
      end
   endtask

   initial begin
      reset = 1;
      start = 0;
      req_cmd = CMD_LOAD;
      req_sample_index = 0;
      req_sample_value = 0;
      req_map_number = 0;
      req_pos_x = 0;
      req_pos_y = 0;
      csr_write = 0;
      csr_index = CSR_MIN_HEIGHT;
      csr_wdata = 0;
      n_sent = 0;
      gaps_on = 1;
      repeat (12) @(posedge clock);
      reset <= 0;

      // Direct heights, loads outside the grid, tile edges and out-of-range positions.
      set_phase(0, 0, 0, MODE_DIRECT, 0, 0, 0, 1);
      load(GRID_DEPTH, 32'h1234_5678);
      load(32767, 32'hffff_ffff);
      load(0, 32'h7fff_ffff);
      load(GRID_DEPTH - 1, 32'h8000_0000);
      tile_query(0, 0);
      tile_query(TILE_Q8X3 - 1, TILE_Q8X3 - 1);
      tile_query(TILE_Q8X3 - 1, 0);
      query(0, 24'h7fffff, 24'h800000);
      query(0, 24'h800000, 24'h7fffff);
      query(0, 0, 0);
      query(1023, pos_in(0, 5000), pos_in(0, 5000));

      // Sixteen-bit codes across the full height range.
      set_phase(32'h8000_0000, 32'h7fff_ffff, 0, MODE_CODE16, 5, 9, 700, 1);
      load(200, 0);
      load(201, 32'hffff_ffff);
      load(202, 32'h1234_8000);
      tile_query(200000, 123456);

      // Eight-bit codes with the range reversed.
      set_phase(32'h7fff_ffff, 32'h8000_0000, 0, MODE_CODE8, 40, 22, 3, 1);
      load(300, 32'h0000_00ff);
      load(301, 32'hffff_ff80);
      tile_query(409000, 700);

      // Unused mode stores directly; a flat tile answers with the minimum height.
      set_phase(32'hffff_ff00, 32'h0000_0100, 1, 2'd3, 63, 63, 1023, 1);
      load(400, 32'hdead_beef);
      tile_query(100, 300000);
      query(1023, pos_in(62, 100), pos_in(63, 100));

      // A tile that is not present gives no ground.
      set_phase(32'h0000_1000, 32'h0000_2000, 0, MODE_DIRECT, 10, 11, 12, 0);
      tile_query(1000, 1000);

      for (int p = 0; p < 12; p++) begin
         set_phase(pick_height(), pick_height(), $urandom_range(0, 4) == 0,
                   $urandom_range(0, 3), $urandom_range(0, 63), $urandom_range(0, 63),
                   ($urandom_range(0, 3) == 0) ? 1023 : $urandom_range(0, 1023),
                   $urandom_range(0, 4) != 0);
         gaps_on = (p != 11);
         random_phase(130);
      end

      start <= 0;
      while (sb.pending.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.errors == 0) begin
         $display("tb_heightfield_bilinear_sampler OK");
      end else begin
         $display("tb_heightfield_bilinear_sampler NOT OK");
      end
      $finish;
   end
endmodule
